// File: sv/pulse_request_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Pulse request scheduler assertion macros
// Clocked assertion helpers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef PULSE_REQUEST_SCHEDULER_MACROS_SVH
`define PULSE_REQUEST_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define PRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define PRS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PRS_ASSERT(label, prop, msg)
`define PRS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: sv/prs_pkg.sv
// ----------------------------------------------------------------------------
// Pulse request scheduler package
// Word types, queue entry type, sizes and codes shared by the scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

	// Queue depth and derived widths
	localparam int SLOTS  = 8;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int TIME_W = 48;
	localparam int PIN_W  = 8;
	localparam int LEN_W  = 16;
	localparam int DROP_W = 16;

	localparam logic [PIN_W-1:0] PIN_NONE = 8'd255;

	// Command codes
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Result kinds
	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_DRIVE = 1'b1;

	// Pending event bits, emitted lowest first
	localparam int EV_ACK     = 0;
	localparam int EV_LOW_OLD = 1;
	localparam int EV_LOW_ILK = 2;
	localparam int EV_HIGH    = 3;
	localparam int EV_N       = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} prs_state_t;

	typedef struct packed {
		logic              cmd;
		logic [PIN_W-1:0]  pin;
		logic [PIN_W-1:0]  interlock;
		logic [TIME_W-1:0] now_ms;
	} prs_in_t;

	typedef struct packed {
		logic              kind;
		logic              accepted;
		logic [PIN_W-1:0]  drive_pin;
		logic              drive_level;
		logic              busy_res;
		logic [DROP_W-1:0] dropped_count;
		logic              last;
	} prs_out_t;

	// One queued request
	typedef struct packed {
		logic [PIN_W-1:0] ilk;
		logic [PIN_W-1:0] pin;
	} ring_entry_t;

	// Per-cell control from the scheduler
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// File: sv/prs_cell.sv
// ----------------------------------------------------------------------------
// Pulse request scheduler queue cell
// Holds one queued request, shifts toward the head on dequeue, and matches
// its pin against the probe pin.
// ----------------------------------------------------------------------------
module prs_cell
	import prs_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic             occupied,
	input  ring_entry_t      nbr_entry,
	input  ring_entry_t      new_entry,
	input  logic [PIN_W-1:0] probe_pin,
	output ring_entry_t      entry,
	output logic             match
);

	ring_entry_t entry_q;

	// Load a new request or take the neighbor's entry on dequeue
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= nbr_entry;
		end
	end

	// Flag a queued duplicate
	assign match = occupied && (entry_q.pin == probe_pin);
	assign entry = entry_q;

endmodule

// File: sv/pulse_request_scheduler.sv
// ----------------------------------------------------------------------------
// Pulse request scheduler
// Queues pin pulse requests in a row of shifting cells and drives one pin
// at a time as a timed pulse on service ticks.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Word
// req       in         req_valid/req_ready   prs_in_t (request or tick)
// res       out        res_valid/res_ready   prs_out_t (ack or drive event)
// cfg       in         cfg_we                cfg_wdata, pulse length in ms
//
// An item passes through capture, evaluation against the cell row, then
// emission, where its results are loaded into the result register in turn
// (a tick with no result still passes through the emit state).
// A new item is taken once all results of the previous one are in the result
// register; a stalled res side holds emission. Reset clears the queue count,
// the active pin, end time, drop counter and pulse length.
// ----------------------------------------------------------------------------
`include "pulse_request_scheduler_macros.svh"

module pulse_request_scheduler
	import prs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  prs_in_t          req,
	output logic             res_valid,
	input  logic             res_ready,
	output prs_out_t         res,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata
);

	prs_state_t state_q, state_d;

	prs_in_t             in_q;
	logic [CNT_W-1:0]    count_q;
	logic [PIN_W-1:0]    active_pin_q;
	logic [TIME_W-1:0]   end_q;
	logic [DROP_W-1:0]   drop_q;
	logic [LEN_W-1:0]    len_q;
	logic [EV_N-1:0]     pend_q;
	logic                acc_q;
	logic                busy_q;
	logic [PIN_W-1:0]    old_pin_q;
	ring_entry_t         new_q;
	logic                out_valid_q;
	prs_out_t            out_q;

	cell_ctl_t           cell_ctl   [SLOTS];
	ring_entry_t         cell_entry [SLOTS];
	logic [SLOTS-1:0]    cell_match;
	logic [SLOTS-1:0]    cell_occ;
	ring_entry_t         req_entry;

	logic                eval, is_req, pin_none, dup, full, enq, drop_inc, acc;
	logic                active_on, expire, go, deq;
	logic [TIME_W:0]     end_sum;
	logic [TIME_W-1:0]   end_sat;
	logic [EV_N-1:0]     sel, rest;
	logic                out_load;
	prs_out_t            out_d;

	assign req_entry = '{ilk: in_q.interlock, pin: in_q.pin};

	// Row of queue cells; cell 0 is the head
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ring_entry_t nbr;
		if (i == SLOTS - 1) begin : g_tail
			assign nbr = '{ilk: PIN_NONE, pin: PIN_NONE};
		end else begin : g_mid
			assign nbr = cell_entry[i+1];
		end
		assign cell_occ[i]       = count_q > CNT_W'(i);
		assign cell_ctl[i].shift = deq;
		assign cell_ctl[i].load  = enq && (count_q == CNT_W'(i));

		prs_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.occupied  (cell_occ[i]),
			.nbr_entry (nbr),
			.new_entry (req_entry),
			.probe_pin (in_q.pin),
			.entry     (cell_entry[i]),
			.match     (cell_match[i])
		);
	end

	// Evaluate the captured word
	assign eval      = state_q == ST_EVAL;
	assign is_req    = in_q.cmd == CMD_REQUEST;
	assign pin_none  = in_q.pin == PIN_NONE;
	assign dup       = (active_pin_q == in_q.pin) || (|cell_match);
	assign full      = count_q == CNT_W'(SLOTS);
	assign enq       = eval && is_req && !pin_none && !dup && !full;
	assign drop_inc  = eval && is_req && !pin_none && !dup && full;
	assign acc       = !pin_none && (dup || !full);
	assign active_on = active_pin_q != PIN_NONE;
	assign expire    = active_on && (in_q.now_ms >= end_q);
	assign go        = !active_on || expire;
	assign deq       = eval && !is_req && go && (count_q != '0);

	// Saturate the pulse end time
	assign end_sum = {1'b0, in_q.now_ms} + (TIME_W+1)'(len_q);
	assign end_sat = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

	// Pick the next pending event, lowest bit first
	assign sel  = pend_q & (~pend_q + EV_N'(1));
	assign rest = pend_q & ~sel;

	always_comb begin
		out_d               = '0;
		out_d.kind          = sel[EV_ACK] ? KIND_ACK : KIND_DRIVE;
		out_d.accepted      = sel[EV_ACK] && acc_q;
		out_d.drive_level   = sel[EV_HIGH];
		out_d.busy_res      = busy_q;
		out_d.dropped_count = drop_q;
		out_d.last          = rest == '0;
		if (sel[EV_LOW_OLD]) begin
			out_d.drive_pin = old_pin_q;
		end else if (sel[EV_LOW_ILK]) begin
			out_d.drive_pin = new_q.ilk;
		end else if (sel[EV_HIGH]) begin
			out_d.drive_pin = new_q.pin;
		end
	end

	assign out_load = (state_q == ST_EMIT) && (pend_q != '0) &&
	                  (!out_valid_q || res_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EVAL;
			end
			ST_EVAL: state_d = ST_EMIT;
			ST_EMIT: begin
				if (pend_q == '0 || (out_load && rest == '0)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_ready = state_q == ST_IDLE;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			active_pin_q <= PIN_NONE;
			end_q        <= '0;
			drop_q       <= '0;
			len_q        <= '0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) len_q <= cfg_wdata;
			if (drop_inc) drop_q <= drop_q + DROP_W'(1);
			if (enq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (eval && !is_req) begin
				if (deq) begin
					active_pin_q <= cell_entry[0].pin;
					end_q        <= end_sat;
				end else if (expire) begin
					active_pin_q <= PIN_NONE;
				end
			end
			if (eval) begin
				if (is_req) begin
					pend_q <= EV_N'(1) << EV_ACK;
				end else begin
					pend_q <= {deq, deq && (cell_entry[0].ilk != PIN_NONE), expire, 1'b0};
				end
			end else if (out_load) begin
				pend_q <= rest;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Word and event payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) in_q <= req;
		if (eval) begin
			acc_q     <= acc;
			old_pin_q <= active_pin_q;
			new_q     <= cell_entry[0];
			busy_q    <= is_req ? (active_on || count_q != '0 || enq) : (!go || deq);
		end
		if (out_load) out_q <= out_d;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`PRS_ASSERT(a_count_bound, count_q <= CNT_W'(SLOTS), "queue count beyond depth")
	`PRS_ASSERT(a_queue_unique, $onehot0(cell_match), "pin queued more than once")
	`PRS_ASSERT_NEVER(a_enq_deq, enq && deq, "enqueue and dequeue in one cycle")
	`PRS_ASSERT(a_idle_clean, state_q == ST_IDLE |-> pend_q == '0, "events left at idle")
	`PRS_ASSERT(a_drop_hold, (state_q != ST_EVAL || in_q.cmd == CMD_TICK) |=> drop_q == $past(drop_q), "drop count moved outside request")

endmodule
